FILE: rtl/qrs_pkg.sv
// qrs_pkg: widths, types and helpers shared by the quadratic root solver
// depends on nothing; every rtl module of the solver imports it
`default_nettype none

package qrs_pkg;

   localparam int COEF_WIDTH = 16;
   localparam int FRAC_BITS  = 24;
   localparam int ROOT_WIDTH = 42;

   // signed discriminant, and its magnitude when positive
   localparam int DS_W  = 2 * COEF_WIDTH + 2;
   localparam int D_W   = 2 * COEF_WIDTH + 1;
   // square root of d * 4^FRAC_BITS
   localparam int SQ_W  = COEF_WIDTH + FRAC_BITS + 1;
   localparam int RAD_W = 2 * SQ_W;
   // numerator magnitude and signed numerator
   localparam int TM_W  = SQ_W + 1;
   localparam int TS_W  = TM_W + 1;
   // divisor 2|a| and division remainder
   localparam int DEN_W = COEF_WIDTH + 1;
   localparam int REM_W = DEN_W;
   localparam int CMP_W = ((TM_W > ROOT_WIDTH) ? TM_W : ROOT_WIDTH) + 1;

   typedef enum logic [1:0] {
      COUNT_NONE = 2'd0,
      COUNT_ONE  = 2'd1,
      COUNT_TWO  = 2'd2
   } count_type;

   typedef struct packed {
      logic [COEF_WIDTH-1:0] a_mag;
      logic                  a_neg;
      logic [COEF_WIDTH-1:0] b;
      count_type             count;
   } sq_meta_type;

   typedef struct packed {
      logic [COEF_WIDTH-1:0] a_mag;
      count_type             count;
   } div_meta_type;

   // sign-magnitude quotient to saturated two's complement root
   function automatic logic [ROOT_WIDTH-1:0] sat_root(input logic [TM_W-1:0] mag,
                                                      input logic neg);
      logic [CMP_W-1:0] m;
      logic [CMP_W-1:0] lim;
      logic [CMP_W-1:0] r;
      m   = CMP_W'(mag);
      lim = CMP_W'(1) << (ROOT_WIDTH - 1);
      if (neg) begin
         if (m > lim) m = lim;
         r = ~m + CMP_W'(1);
      end else begin
         if (m > lim - CMP_W'(1)) m = lim - CMP_W'(1);
         r = m;
      end
      return r[ROOT_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/quadratic_real_root_solver.sv
// quadratic_real_root_solver: top level of the real root solver for a*x^2 + b*x + c
// depends on qrs_pkg, qrs_disc, qrs_sqrt and qrs_div
`default_nettype none

// Takes one equation (16 bit signed a, b, c) per req transaction and returns one rsp
// transaction with the number of real roots and up to two roots in signed fixed point
// with 24 fractional bits, rounded to nearest with ties toward plus infinity. The first
// root is (-b - sqrt(d)) / 2a, the second (-b + sqrt(d)) / 2a, unsorted; a single root
// comes in the first slot. Invalid roots read as zero with their valid flag low, and
// a = 0 gives no roots. The discriminant is exact. One equation can enter every cycle;
// it passes through the discriminant unit, the bit per stage square root, the numerator
// register, the bit per stage divider and the output register.
// The whole pipeline advances together; it stops only when a result is waiting in the
// output register and another one is ready behind it, so bubbles still fill while the
// output is held.
module quadratic_real_root_solver import qrs_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COEF_WIDTH-1:0] req_coef_a,
   input  logic signed [COEF_WIDTH-1:0] req_coef_b,
   input  logic signed [COEF_WIDTH-1:0] req_coef_c,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_root_count,
   output logic                         rsp_first_valid,
   output logic signed [ROOT_WIDTH-1:0] rsp_first_root,
   output logic                         rsp_second_valid,
   output logic signed [ROOT_WIDTH-1:0] rsp_second_root
);

   // pipeline enable and output hold
   logic                   out_hold;
   logic                   en;

   // discriminant to square root
   logic                   disc_valid;
   logic [D_W-1:0]         disc_rad;
   sq_meta_type            disc_meta;

   // square root to numerator stage
   logic                   sq_valid;
   logic [SQ_W-1:0]        sq_root;
   logic                   sq_exact;
   sq_meta_type            sq_meta;

   // numerator stage
   logic                   num_valid_ff;
   logic signed [TS_W-1:0] t1_ff;
   logic signed [TS_W-1:0] t2_ff;
   div_meta_type           num_meta_ff;
   logic signed [TS_W-1:0] t1_in;
   logic signed [TS_W-1:0] t2_in;
   logic signed [TS_W-1:0] bsh_w;
   logic signed [TS_W-1:0] am_w;
   logic signed [TS_W-1:0] sq_w;
   logic signed [TS_W-1:0] sqn_w;

   // divider out
   logic                   div_valid;
   logic [TM_W-1:0]        div_q1;
   logic [TM_W-1:0]        div_q2;
   logic                   div_neg1;
   logic                   div_neg2;
   div_meta_type           div_meta;

   // output register
   logic                   rsp_valid_ff;
   logic [1:0]             count_ff;
   logic                   first_valid_ff;
   logic [ROOT_WIDTH-1:0]  first_root_ff;
   logic                   second_valid_ff;
   logic [ROOT_WIDTH-1:0]  second_root_ff;
   logic                   first_valid_in;
   logic                   second_valid_in;

   assign out_hold  = rsp_valid_ff && !rsp_ready;
   assign en        = !(out_hold && div_valid);
   assign req_ready = en;

   qrs_disc u_disc (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .coef_a    (req_coef_a),
      .coef_b    (req_coef_b),
      .coef_c    (req_coef_c),
      .out_valid (disc_valid),
      .out_rad   (disc_rad),
      .out_meta  (disc_meta)
   );

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (disc_valid),
      .in_rad    (disc_rad),
      .in_meta   (disc_meta),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_exact (sq_exact),
      .out_meta  (sq_meta)
   );

   // numerators scaled by the sign of a, with a added for round to nearest;
   // a subtracted root uses the ceiling so the floor division stays exact
   always_comb begin
      bsh_w = sq_meta.a_neg ? TS_W'($signed(sq_meta.b)) : -TS_W'($signed(sq_meta.b));
      bsh_w = bsh_w <<< FRAC_BITS;
      am_w  = $signed(TS_W'(sq_meta.a_mag));
      sq_w  = $signed(TS_W'(sq_root));
      sqn_w = $signed(TS_W'(sq_root) + TS_W'(!sq_exact));
      t1_in = bsh_w + am_w + (sq_meta.a_neg ? sq_w : -sqn_w);
      t2_in = bsh_w + am_w + (sq_meta.a_neg ? -sqn_w : sq_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff <= 1'b0;
      end else if (en) begin
         num_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff             <= t1_in;
         t2_ff             <= t2_in;
         num_meta_ff.a_mag <= sq_meta.a_mag;
         num_meta_ff.count <= sq_meta.count;
      end
   end

   qrs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (num_valid_ff),
      .in_t1     (t1_ff),
      .in_t2     (t2_ff),
      .in_meta   (num_meta_ff),
      .out_valid (div_valid),
      .out_q1    (div_q1),
      .out_q2    (div_q2),
      .out_neg1  (div_neg1),
      .out_neg2  (div_neg2),
      .out_meta  (div_meta)
   );

   assign first_valid_in  = (div_meta.count != COUNT_NONE);
   assign second_valid_in = (div_meta.count == COUNT_TWO);

   // output register holds while the consumer stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!out_hold) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_hold && div_valid) begin
         count_ff        <= div_meta.count;
         first_valid_ff  <= first_valid_in;
         second_valid_ff <= second_valid_in;
         first_root_ff   <= first_valid_in ? sat_root(div_q1, div_neg1) : '0;
         second_root_ff  <= second_valid_in ? sat_root(div_q2, div_neg2) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_root_count   = count_ff;
   assign rsp_first_valid  = first_valid_ff;
   assign rsp_first_root   = first_root_ff;
   assign rsp_second_valid = second_valid_ff;
   assign rsp_second_root  = second_root_ff;

endmodule

`default_nettype wire

FILE: rtl/qrs_disc.sv
// qrs_disc: two stage discriminant unit, b*b and a*c then b^2 - 4ac
// depends on qrs_pkg
`default_nettype none

module qrs_disc import qrs_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic signed [COEF_WIDTH-1:0] coef_a,
   input  logic signed [COEF_WIDTH-1:0] coef_b,
   input  logic signed [COEF_WIDTH-1:0] coef_c,
   output logic                         out_valid,
   output logic [D_W-1:0]               out_rad,
   output sq_meta_type                  out_meta
);

   logic                           v1_ff;
   logic signed [2*COEF_WIDTH-1:0] bb_ff;
   logic signed [2*COEF_WIDTH-1:0] ac_ff;
   logic signed [COEF_WIDTH-1:0]   a_ff;
   logic signed [COEF_WIDTH-1:0]   b_ff;
   logic signed [2*COEF_WIDTH-1:0] bb_in;
   logic signed [2*COEF_WIDTH-1:0] ac_in;

   logic                           v2_ff;
   logic [D_W-1:0]                 rad_ff;
   sq_meta_type                    meta_ff;
   logic signed [DS_W-1:0]         d_in;
   logic [COEF_WIDTH-1:0]          a_mag_in;
   count_type                      count_in;
   logic [D_W-1:0]                 rad_in;

   assign bb_in = coef_b * coef_b;
   assign ac_in = coef_a * coef_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bb_ff <= bb_in;
         ac_ff <= ac_in;
         a_ff  <= coef_a;
         b_ff  <= coef_b;
      end
   end

   always_comb begin
      d_in     = DS_W'(bb_ff) - (DS_W'(ac_ff) <<< 2);
      a_mag_in = a_ff[COEF_WIDTH-1] ? (~a_ff + 1'b1) : a_ff;
      priority if (a_ff == '0) begin
         count_in = COUNT_NONE;
      end else if (d_in[DS_W-1]) begin
         count_in = COUNT_NONE;
      end else if (d_in == '0) begin
         count_in = COUNT_ONE;
      end else begin
         count_in = COUNT_TWO;
      end
      rad_in = d_in[DS_W-1] ? '0 : d_in[D_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff        <= rad_in;
         meta_ff.a_mag <= a_mag_in;
         meta_ff.a_neg <= a_ff[COEF_WIDTH-1];
         meta_ff.b     <= b_ff;
         meta_ff.count <= count_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_rad   = rad_ff;
   assign out_meta  = meta_ff;

endmodule

`default_nettype wire

FILE: rtl/qrs_sqrt.sv
// qrs_sqrt: pipelined digit by digit integer square root, one root bit per stage
// depends on qrs_pkg
`default_nettype none

module qrs_sqrt import qrs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [D_W-1:0]  in_rad,
   input  sq_meta_type     in_meta,
   output logic            out_valid,
   output logic [SQ_W-1:0] out_root,
   output logic            out_exact,
   output sq_meta_type     out_meta
);

   localparam int REMS_W = SQ_W + 2;

   logic [SQ_W:0]       valid_ff;
   logic [REMS_W-1:0]   rem_ff  [0:SQ_W];
   logic [SQ_W-1:0]     root_ff [0:SQ_W];
   logic [RAD_W-1:0]    x_ff    [0:SQ_W-1];
   sq_meta_type         meta_ff [0:SQ_W];

   logic [REMS_W-1:0]   rem_in  [1:SQ_W];
   logic [SQ_W-1:0]     root_in [1:SQ_W];

   always_comb begin
      logic [REMS_W-1:0] sh;
      logic [REMS_W-1:0] tr;
      for (int k = 1; k <= SQ_W; k++) begin
         sh = {rem_ff[k-1][REMS_W-3:0], x_ff[k-1][RAD_W-1 -: 2]};
         tr = {root_ff[k-1], 2'b01};
         if (sh >= tr) begin
            rem_in[k]  = sh - tr;
            root_in[k] = {root_ff[k-1][SQ_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = sh;
            root_in[k] = {root_ff[k-1][SQ_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[SQ_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         x_ff[0]    <= RAD_W'(in_rad) << (2 * FRAC_BITS);
         meta_ff[0] <= in_meta;
         for (int k = 1; k <= SQ_W; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            meta_ff[k] <= meta_ff[k-1];
         end
         for (int k = 1; k < SQ_W; k++) begin
            x_ff[k] <= x_ff[k-1] << 2;
         end
      end
   end

   assign out_valid = valid_ff[SQ_W];
   assign out_root  = root_ff[SQ_W];
   assign out_exact = (rem_ff[SQ_W] == '0);
   assign out_meta  = meta_ff[SQ_W];

endmodule

`default_nettype wire

FILE: rtl/qrs_div.sv
// qrs_div: two lane pipelined restoring divider, floor(t / 2|a|) per lane
// depends on qrs_pkg
`default_nettype none

module qrs_div import qrs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic signed [TS_W-1:0] in_t1,
   input  logic signed [TS_W-1:0] in_t2,
   input  div_meta_type           in_meta,
   output logic                   out_valid,
   output logic [TM_W-1:0]        out_q1,
   output logic [TM_W-1:0]        out_q2,
   output logic                   out_neg1,
   output logic                   out_neg2,
   output div_meta_type           out_meta
);

   logic [TM_W+1:0]     valid_ff;
   logic [TM_W-1:0]     n_ff   [0:TM_W-1][0:1];
   logic [REM_W-1:0]    rem_ff [0:TM_W][0:1];
   logic [TM_W-1:0]     q_ff   [0:TM_W][0:1];
   logic                neg_ff [0:TM_W][0:1];
   div_meta_type        meta_ff [0:TM_W];

   logic [REM_W-1:0]    rem_in [1:TM_W][0:1];
   logic [TM_W-1:0]     q_in   [1:TM_W][0:1];
   logic signed [TS_W-1:0] t_in [0:1];

   logic [TM_W-1:0]     qa_ff  [0:1];
   logic                nego_ff [0:1];
   div_meta_type        metao_ff;

   assign t_in[0] = in_t1;
   assign t_in[1] = in_t2;

   always_comb begin
      logic [REM_W-1:0] sh;
      logic [DEN_W-1:0] den;
      for (int k = 1; k <= TM_W; k++) begin
         den = {meta_ff[k-1].a_mag, 1'b0};
         for (int l = 0; l < 2; l++) begin
            sh = {rem_ff[k-1][l][REM_W-2:0], n_ff[k-1][l][TM_W-1]};
            if (sh >= den) begin
               rem_in[k][l] = sh - den;
               q_in[k][l]   = {q_ff[k-1][l][TM_W-2:0], 1'b1};
            end else begin
               rem_in[k][l] = sh;
               q_in[k][l]   = {q_ff[k-1][l][TM_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[TM_W:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 2; l++) begin
            neg_ff[0][l] <= t_in[l][TS_W-1];
            n_ff[0][l]   <= t_in[l][TS_W-1] ? TM_W'(-t_in[l]) : TM_W'(t_in[l]);
            rem_ff[0][l] <= '0;
            q_ff[0][l]   <= '0;
            for (int k = 1; k <= TM_W; k++) begin
               rem_ff[k][l] <= rem_in[k][l];
               q_ff[k][l]   <= q_in[k][l];
               neg_ff[k][l] <= neg_ff[k-1][l];
            end
            for (int k = 1; k < TM_W; k++) begin
               n_ff[k][l] <= n_ff[k-1][l] << 1;
            end
            // floor of a negative quotient rounds the magnitude up
            qa_ff[l]   <= q_ff[TM_W][l]
                          + TM_W'(neg_ff[TM_W][l] && (rem_ff[TM_W][l] != '0));
            nego_ff[l] <= neg_ff[TM_W][l];
         end
         meta_ff[0] <= in_meta;
         for (int k = 1; k <= TM_W; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
         metao_ff <= meta_ff[TM_W];
      end
   end

   assign out_valid = valid_ff[TM_W+1];
   assign out_q1    = qa_ff[0];
   assign out_q2    = qa_ff[1];
   assign out_neg1  = nego_ff[0];
   assign out_neg2  = nego_ff[1];
   assign out_meta  = metao_ff;

endmodule

`default_nettype wire

FILE: rtl/qrs_checker.sv
// qrs_checker: port level checks on the quadratic root solver, bound to its top level
// depends on qrs_pkg and quadratic_real_root_solver
`default_nettype none

module qrs_checker import qrs_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [1:0]                   rsp_root_count,
   input logic                         rsp_first_valid,
   input logic signed [ROOT_WIDTH-1:0] rsp_first_root,
   input logic                         rsp_second_valid,
   input logic signed [ROOT_WIDTH-1:0] rsp_second_root
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_root_count)
         && $stable(rsp_first_root) && $stable(rsp_second_root))
      else $error("rsp transaction changed while stalled");

   // flags follow the root count
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_first_valid == (rsp_root_count != COUNT_NONE))
         && (rsp_second_valid == (rsp_root_count == COUNT_TWO)))
      else $error("valid flags disagree with root count");

   // invalid roots read as zero
   a_zero_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_first_valid || rsp_first_root == '0)
         && (rsp_second_valid || rsp_second_root == '0))
      else $error("invalid root not cleared");

   // an empty output register never blocks the input
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind quadratic_real_root_solver qrs_checker u_qrs_checker (.*);

`default_nettype wire
